### rtl/dbrt_pkg.sv
// Shared types and constants for the delay-based rate target block.
package dbrt_pkg;

    localparam int RTT_W      = 32;
    localparam int RATE_W     = 40;
    localparam int TIME_W     = 48;
    localparam int THRESH_W   = 24;
    localparam int HEADROOM_W = 12;
    localparam int BACKOFF_W  = 9;
    localparam int WINDOW_W   = 32;
    localparam int GAIN_W     = HEADROOM_W;
    localparam int GAIN_FRAC  = 8;
    localparam int PROD_W     = RATE_W + GAIN_W;
    localparam int SCALED_W   = PROD_W - GAIN_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REGION_W   = 2;

    localparam logic [REGION_W-1:0] REGION_PROBE   = 2'd0;
    localparam logic [REGION_W-1:0] REGION_HOLD    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_BACKOFF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd4;

    localparam logic [THRESH_W-1:0]   LOW_THRESH_RST  = 24'd10000;
    localparam logic [THRESH_W-1:0]   HIGH_THRESH_RST = 24'd50000;
    localparam logic [HEADROOM_W-1:0] HEADROOM_RST    = 12'd384;
    localparam logic [BACKOFF_W-1:0]  BACKOFF_RST     = 9'd218;
    localparam logic [WINDOW_W-1:0]   WINDOW_RST      = 32'd10000000;

    typedef struct packed {
        logic              rtt_present;
        logic [RTT_W-1:0]  rtt_us;
        logic              throughput_present;
        logic [RATE_W-1:0] measured_bps;
        logic              cap_present;
        logic [RATE_W-1:0] cap_bps;
        logic [TIME_W-1:0] time_us;
    } sample_t;

    typedef struct packed {
        logic                rate_valid;
        logic [RATE_W-1:0]   rate_bps;
        logic [RTT_W-1:0]    queue_delay_us;
        logic [REGION_W-1:0] region;
        logic [RTT_W-1:0]    base_rtt_us;
    } rate_t;

    typedef struct packed {
        logic [THRESH_W-1:0] low_thresh;
        logic [THRESH_W-1:0] high_thresh;
        logic [WINDOW_W-1:0] window;
    } track_cfg_t;

    typedef struct packed {
        logic                used;
        logic [RTT_W-1:0]    queue;
        logic [REGION_W-1:0] region;
        logic [RTT_W-1:0]    base;
    } track_t;

endpackage

### rtl/dbrt_if.sv
// Valid/ready channel interfaces for samples and rate results.
interface dbrt_sample_if;
    import dbrt_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dbrt_rate_if;
    import dbrt_pkg::*;

    logic  valid;
    logic  ready;
    rate_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/delay_based_rate_target.sv
// Delay-based rate target: turns interval samples into a raw target rate.
//
// Samples enter on the sample channel (valid/ready, one transaction per
// sample) and exactly one result leaves on the result channel per sample.
// Configuration registers are written on cfg_we/cfg_index/cfg_wdata while
// no sample is in flight; unknown indexes are ignored.
//
// Pipeline: input register, base tracker stage (base RTT, window minimum,
// queue delay, region), then gain multiply, cap and saturation into the
// output register. Throughput is one sample per cycle while the receiver
// keeps ready high: the base tracker state updates as a sample leaves its
// stage, so the next sample sees it immediately.
//
// Reset clears the pipeline, the base tracker state and restores register
// defaults. When the receiver holds ready low, the result holds and the
// stages behind it keep filling; sample ready drops only once all three
// stages are full.
module delay_based_rate_target (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    dbrt_sample_if.sink                     sample,
    dbrt_rate_if.source                     result
);
    import dbrt_pkg::*;

    logic [THRESH_W-1:0]   low_thresh_reg;
    logic [THRESH_W-1:0]   high_thresh_reg;
    logic [HEADROOM_W-1:0] headroom_reg;
    logic [BACKOFF_W-1:0]  backoff_reg;
    logic [WINDOW_W-1:0]   window_reg;

    logic    s0_valid_reg;
    sample_t s0_data_reg;
    logic    s1_valid_reg;
    track_t  s1_trk_reg;
    logic [RATE_W-1:0] s1_thr_reg;
    logic              s1_cap_present_reg;
    logic [RATE_W-1:0] s1_cap_reg;
    logic    out_valid_reg;
    rate_t   out_data_reg;
    rate_t   out_data_next;

    logic out_adv;
    logic s1_adv;
    logic s0_adv;

    track_cfg_t trk_cfg;
    track_t     trk;

    logic [GAIN_W-1:0]   gain;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] capped;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thresh_reg  <= LOW_THRESH_RST;
            high_thresh_reg <= HIGH_THRESH_RST;
            headroom_reg    <= HEADROOM_RST;
            backoff_reg     <= BACKOFF_RST;
            window_reg      <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_THRESH:  low_thresh_reg  <= cfg_wdata[THRESH_W-1:0];
                CFG_HIGH_THRESH: high_thresh_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_HEADROOM:    headroom_reg    <= cfg_wdata[HEADROOM_W-1:0];
                CFG_BACKOFF:     backoff_reg     <= cfg_wdata[BACKOFF_W-1:0];
                CFG_WINDOW:      window_reg      <= cfg_wdata[WINDOW_W-1:0];
                default:         ;
            endcase
        end
    end

    // stage handshake: each stage loads when empty or when it drains
    assign out_adv      = !out_valid_reg || result.ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign s0_adv       = !s0_valid_reg || s1_adv;
    assign sample.ready = s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_adv)
                s0_valid_reg <= sample.valid;
            if (s1_adv)
                s1_valid_reg <= s0_valid_reg;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv && sample.valid)
            s0_data_reg <= sample.data;
        if (s1_adv && s0_valid_reg)
        begin
            s1_trk_reg         <= trk;
            s1_thr_reg         <= s0_data_reg.measured_bps;
            s1_cap_present_reg <= s0_data_reg.cap_present;
            s1_cap_reg         <= s0_data_reg.cap_bps;
        end
        if (out_adv && s1_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign trk_cfg.low_thresh  = low_thresh_reg;
    assign trk_cfg.high_thresh = high_thresh_reg;
    assign trk_cfg.window      = window_reg;

    dbrt_base_track u_base_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv && s0_valid_reg),
        .smp     (s0_data_reg),
        .cfg     (trk_cfg),
        .trk     (trk)
    );

    // gain multiply (bypassed in the hold region), truncate the Q.8 fraction, cap, then saturate
    always_comb
    begin
        if (s1_trk_reg.region == REGION_PROBE)
            gain = headroom_reg;
        else
            gain = {{(GAIN_W-BACKOFF_W){1'b0}}, backoff_reg};

        prod = {{GAIN_W{1'b0}}, s1_thr_reg} * {{RATE_W{1'b0}}, gain};

        if (s1_trk_reg.region == REGION_HOLD)
            scaled = {{(SCALED_W-RATE_W){1'b0}}, s1_thr_reg};
        else
            scaled = prod[PROD_W-1:GAIN_FRAC];

        if (s1_cap_present_reg && ({{(SCALED_W-RATE_W){1'b0}}, s1_cap_reg} < scaled))
            capped = {{(SCALED_W-RATE_W){1'b0}}, s1_cap_reg};
        else
            capped = scaled;

        out_data_next.rate_valid     = s1_trk_reg.used;
        out_data_next.queue_delay_us = s1_trk_reg.queue;
        out_data_next.region         = s1_trk_reg.region;
        out_data_next.base_rtt_us    = s1_trk_reg.base;
        if (!s1_trk_reg.used)
            out_data_next.rate_bps = '0;
        else if (capped[SCALED_W-1:RATE_W] != '0)
            out_data_next.rate_bps = '1;
        else
            out_data_next.rate_bps = capped[RATE_W-1:0];
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

### rtl/dbrt_base_track.sv
// Base RTT tracker: running and windowed minimum, queue delay and region.
module dbrt_base_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  dbrt_pkg::sample_t    smp,
    input  dbrt_pkg::track_cfg_t cfg,
    output dbrt_pkg::track_t     trk
);
    import dbrt_pkg::*;

    logic              base_known_reg, base_known_next;
    logic [RTT_W-1:0]  base_rtt_reg, base_rtt_next;
    logic [RTT_W-1:0]  win_min_reg, win_min_next;
    logic [TIME_W-1:0] win_start_reg, win_start_next;

    logic              used;
    logic [RTT_W-1:0]  run_base;
    logic [RTT_W-1:0]  run_min;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic [RTT_W-1:0]  queue;

    always_comb
    begin
        used     = smp.rtt_present && smp.throughput_present && (smp.rtt_us != '0);
        run_base = (smp.rtt_us < base_rtt_reg) ? smp.rtt_us : base_rtt_reg;
        run_min  = (smp.rtt_us < win_min_reg) ? smp.rtt_us : win_min_reg;
        elapsed  = smp.time_us - win_start_reg;
        expired  = elapsed > {{(TIME_W-WINDOW_W){1'b0}}, cfg.window};

        base_known_next = 1'b1;
        if (!base_known_reg)
        begin
            base_rtt_next  = smp.rtt_us;
            win_min_next   = smp.rtt_us;
            win_start_next = smp.time_us;
        end
        else if (expired)
        begin
            // re-anchor the base to the window minimum and open a new window
            base_rtt_next  = run_min;
            win_min_next   = smp.rtt_us;
            win_start_next = smp.time_us;
        end
        else
        begin
            base_rtt_next  = run_base;
            win_min_next   = run_min;
            win_start_next = win_start_reg;
        end

        queue = smp.rtt_us - base_rtt_next;

        trk.used = used;
        if (used)
        begin
            trk.queue = queue;
            trk.base  = base_rtt_next;
            // probe-up test first so it wins when thresholds cross
            if (queue <= {{(RTT_W-THRESH_W){1'b0}}, cfg.low_thresh})
                trk.region = REGION_PROBE;
            else if (queue >= {{(RTT_W-THRESH_W){1'b0}}, cfg.high_thresh})
                trk.region = REGION_BACKOFF;
            else
                trk.region = REGION_HOLD;
        end
        else
        begin
            trk.queue  = '0;
            trk.base   = base_rtt_reg;
            trk.region = REGION_PROBE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_known_reg <= 1'b0;
            base_rtt_reg   <= '0;
            win_min_reg    <= '0;
            win_start_reg  <= '0;
        end
        else if (advance && used)
        begin
            base_known_reg <= base_known_next;
            base_rtt_reg   <= base_rtt_next;
            win_min_reg    <= win_min_next;
            win_start_reg  <= win_start_next;
        end
    end

endmodule

### rtl/dbrt_checker.sv
// Port-level checker for the delay-based rate target, bound to the top level.
module dbrt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input dbrt_pkg::rate_t   out_data
);
    import dbrt_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // skipped samples carry zero rate, delay and region
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.rate_valid |->
            out_data.rate_bps == '0 && out_data.queue_delay_us == '0 &&
            out_data.region == REGION_PROBE)
        else $error("skipped sample carries nonzero fields");

    // the base is a minimum of nonzero RTTs once a sample is used
    a_base_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rate_valid |-> out_data.base_rtt_us != '0)
        else $error("used sample reports zero base RTT");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.region == REGION_PROBE || out_data.region == REGION_HOLD ||
            out_data.region == REGION_BACKOFF)
        else $error("result region out of range");

endmodule

bind delay_based_rate_target dbrt_checker u_dbrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

### tb/delay_based_rate_target_tb.sv
// Self-checking testbench for the delay-based rate target block.
`timescale 1ns / 1ps

module delay_based_rate_target_tb;
    import dbrt_pkg::*;

    localparam int                  HALF_PERIOD = 2;
    localparam int                  RESET_CYCLES = 12;
    localparam int                  STALL_LIMIT = 5000;
    localparam int                  MAX_REPORTS = 10;
    localparam int                  PHASE_ITEMS = 90;
    localparam logic [RATE_W-1:0]   RATE_MAX = '1;

    typedef struct {
        sample_t s;
        bit      typed;
        rate_t   want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dbrt_sample_if smp ();
    dbrt_rate_if   res ();

    // Local copy of the rate controller: settings and base RTT tracking.
    logic [THRESH_W-1:0]   low_thresh_us;
    logic [THRESH_W-1:0]   high_thresh_us;
    logic [HEADROOM_W-1:0] probe_gain;
    logic [BACKOFF_W-1:0]  cut_gain;
    logic [WINDOW_W-1:0]   span_us;
    logic                  have_floor;
    logic [RTT_W-1:0]      floor_rtt;
    logic [RTT_W-1:0]      span_min_rtt;
    logic [TIME_W-1:0]     span_start;

    rate_t       expected_rates[$];
    row_t        directed_rows[$];
    int unsigned fails = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 46;
    logic [TIME_W-1:0] now_us = '0;

    delay_based_rate_target i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (smp),
        .result    (res)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic sample_t mk_sample(input logic rp, input logic [RTT_W-1:0] rtt,
                                          input logic tp, input logic [RATE_W-1:0] thr,
                                          input logic cp, input logic [RATE_W-1:0] cap,
                                          input logic [TIME_W-1:0] t);
        sample_t s;
        s.rtt_present        = rp;
        s.rtt_us             = rtt;
        s.throughput_present = tp;
        s.measured_bps       = thr;
        s.cap_present        = cp;
        s.cap_bps            = cap;
        s.time_us            = t;
        return s;
    endfunction

    function automatic rate_t mk_rate(input logic v, input logic [RATE_W-1:0] rate,
                                      input logic [RTT_W-1:0] q,
                                      input logic [REGION_W-1:0] rg,
                                      input logic [RTT_W-1:0] base);
        rate_t r;
        r.rate_valid     = v;
        r.rate_bps       = rate;
        r.queue_delay_us = q;
        r.region         = rg;
        r.base_rtt_us    = base;
        return r;
    endfunction

    // Advance the base RTT tracker by one sample and return the target rate.
    function automatic rate_t predict_rate(input sample_t s);
        rate_t               r;
        logic [PROD_W-1:0]   prod;
        logic [SCALED_W-1:0] scaled;
        logic [TIME_W-1:0]   age;
        r = '0;
        r.base_rtt_us = floor_rtt;
        if (!s.rtt_present || !s.throughput_present || s.rtt_us == '0)
            return r;

        if (!have_floor)
        begin
            have_floor   = 1'b1;
            floor_rtt    = s.rtt_us;
            span_min_rtt = s.rtt_us;
            span_start   = s.time_us;
        end
        else
        begin
            if (s.rtt_us < floor_rtt)
                floor_rtt = s.rtt_us;
            if (s.rtt_us < span_min_rtt)
                span_min_rtt = s.rtt_us;
            age = s.time_us - span_start;
            // re-anchor the base to the minimum seen over the expired window
            if (age > TIME_W'(span_us))
            begin
                floor_rtt    = span_min_rtt;
                span_min_rtt = s.rtt_us;
                span_start   = s.time_us;
            end
        end

        r.rate_valid     = 1'b1;
        r.queue_delay_us = s.rtt_us - floor_rtt;
        r.base_rtt_us    = floor_rtt;
        if (r.queue_delay_us <= RTT_W'(low_thresh_us))
        begin
            r.region = REGION_PROBE;
            prod     = PROD_W'(s.measured_bps) * PROD_W'(probe_gain);
            scaled   = prod[PROD_W-1:GAIN_FRAC];
        end
        else if (r.queue_delay_us >= RTT_W'(high_thresh_us))
        begin
            r.region = REGION_BACKOFF;
            prod     = PROD_W'(s.measured_bps) * PROD_W'(cut_gain);
            scaled   = prod[PROD_W-1:GAIN_FRAC];
        end
        else
        begin
            r.region = REGION_HOLD;
            scaled   = SCALED_W'(s.measured_bps);
        end
        if (s.cap_present && SCALED_W'(s.cap_bps) < scaled)
            scaled = SCALED_W'(s.cap_bps);
        if (scaled > SCALED_W'(RATE_MAX))
            scaled = SCALED_W'(RATE_MAX);
        r.rate_bps = scaled[RATE_W-1:0];
        return r;
    endfunction

    task automatic check_rate(input rate_t got);
        rate_t want;
        if (expected_rates.size() == 0)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("unexpected rate: valid %0b rate %0d queue %0d region %0d base %0d",
                         got.rate_valid, got.rate_bps, got.queue_delay_us, got.region,
                         got.base_rtt_us);
        end
        else
        begin
            want = expected_rates.pop_front();
            if (got.rate_valid !== want.rate_valid || got.rate_bps !== want.rate_bps ||
                got.queue_delay_us !== want.queue_delay_us || got.region !== want.region ||
                got.base_rtt_us !== want.base_rtt_us)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("mismatch exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                             want.rate_valid, want.rate_bps, want.queue_delay_us, want.region,
                             want.base_rtt_us, got.rate_valid, got.rate_bps,
                             got.queue_delay_us, got.region, got.base_rtt_us);
            end
        end
    endtask

    always @(negedge clk)
        res.ready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            check_rate(res.data);
        if (!rst_n || (smp.valid && smp.ready) || (res.valid && res.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input sample_t s, input bit typed, input rate_t want);
        rate_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            smp.valid = 1'b0;
            @(negedge clk);
        end
        smp.valid = 1'b1;
        smp.data  = s;
        do
            @(posedge clk);
        while (!smp.ready);
        predicted = predict_rate(s);
        expected_rates.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        smp.valid = 1'b0;
        while (expected_rates.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge clk);
        case (idx)
            CFG_LOW_THRESH:  low_thresh_us  = value[THRESH_W-1:0];
            CFG_HIGH_THRESH: high_thresh_us = value[THRESH_W-1:0];
            CFG_HEADROOM:    probe_gain     = value[HEADROOM_W-1:0];
            CFG_BACKOFF:     cut_gain       = value[BACKOFF_W-1:0];
            CFG_WINDOW:      span_us        = value[WINDOW_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
                             input logic [CFG_DATA_W-1:0] head,
                             input logic [CFG_DATA_W-1:0] back,
                             input logic [CFG_DATA_W-1:0] win,
                             input int unsigned send_pct, input int unsigned recv_pct);
        sample_t           s;
        logic [TIME_W-1:0] step;
        drain();
        write_reg(CFG_LOW_THRESH, low);
        write_reg(CFG_HIGH_THRESH, high);
        write_reg(CFG_HEADROOM, head);
        write_reg(CFG_BACKOFF, back);
        write_reg(CFG_WINDOW, win);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;

        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            // hold the sender until the pipeline is empty
            if (n == PHASE_ITEMS / 2)
                drain();

            case ($urandom_range(7)) inside
                0:       step = '0;
                [1:3]:   step = TIME_W'($urandom_range(1000));
                4:       step = TIME_W'(span_us);
                5:       step = TIME_W'(span_us) + 1'b1;
                6:       step = TIME_W'($urandom_range(span_us));
                default: step = TIME_W'({$urandom, $urandom});
            endcase
            now_us = now_us + step;

            s.rtt_present        = 1'b1;
            s.throughput_present = 1'b1;
            s.time_us            = now_us;
            case ($urandom_range(9)) inside
                0:       s.rtt_us = $urandom;
                1:       s.rtt_us = (floor_rtt > 1) ? $urandom_range(floor_rtt - 1, 1) : 32'd1;
                [2:3]:   s.rtt_us = floor_rtt + $urandom_range(low_thresh_us);
                4:       s.rtt_us = floor_rtt + low_thresh_us;
                5:       s.rtt_us = floor_rtt + low_thresh_us + 1;
                6:       s.rtt_us = floor_rtt + high_thresh_us - 1;
                7:       s.rtt_us = floor_rtt + high_thresh_us;
                default: s.rtt_us = floor_rtt + $urandom_range(2 * high_thresh_us + 2);
            endcase
            if (s.rtt_us == '0)
                s.rtt_us = 1;
            case ($urandom_range(5)) inside
                0:       s.measured_bps = '0;
                1:       s.measured_bps = RATE_MAX;
                [2:3]:   s.measured_bps = RATE_W'($urandom_range(100000));
                default: s.measured_bps = RATE_W'({$urandom, $urandom});
            endcase
            s.cap_present = ($urandom_range(2) == 0);
            case ($urandom_range(3))
                0:       s.cap_bps = '0;
                1:       s.cap_bps = RATE_MAX;
                2:       s.cap_bps = s.measured_bps >> $urandom_range(3);
                default: s.cap_bps = RATE_W'({$urandom, $urandom});
            endcase

            // break a share of the samples so they get skipped
            if ($urandom_range(99) < 12)
            begin
                case ($urandom_range(2))
                    0:       s.rtt_present = 1'b0;
                    1:       s.throughput_present = 1'b0;
                    default: s.rtt_us = '0;
                endcase
                if ($urandom_range(1) == 0)
                    s.rtt_us = $urandom;
            end
            send_sample(s, 1'b0, '0);
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_LOW_THRESH;
        cfg_wdata      = '0;
        smp.valid      = 1'b0;
        smp.data       = '0;
        res.ready      = 1'b0;
        low_thresh_us  = LOW_THRESH_RST;
        high_thresh_us = HIGH_THRESH_RST;
        probe_gain     = HEADROOM_RST;
        cut_gain       = BACKOFF_RST;
        span_us        = WINDOW_RST;
        have_floor     = 1'b0;
        floor_rtt      = '0;
        span_min_rtt   = '0;
        span_start     = '0;

        // skipped samples before any base is known
        directed_rows.push_back('{mk_sample(0, 1000, 1, 5000, 0, 0, 0), 1'b1,
                                  mk_rate(0, 0, 0, REGION_PROBE, 0)});
        directed_rows.push_back('{mk_sample(1, 100, 0, 5000, 1, 7, 10), 1'b1,
                                  mk_rate(0, 0, 0, REGION_PROBE, 0)});
        directed_rows.push_back('{mk_sample(1, 0, 1, 5000, 0, 0, 20), 1'b1,
                                  mk_rate(0, 0, 0, REGION_PROBE, 0)});
        // first used sample anchors the base
        directed_rows.push_back('{mk_sample(1, 1000, 1, 1000, 0, 0, 0), 1'b1,
                                  mk_rate(1, 1500, 0, REGION_PROBE, 1000)});
        directed_rows.push_back('{mk_sample(1, 31000, 1, 1000000, 0, 0, 100), 1'b1,
                                  mk_rate(1, 1000000, 30000, REGION_HOLD, 1000)});
        directed_rows.push_back('{mk_sample(1, 51000, 1, 256000, 0, 0, 200), 1'b1,
                                  mk_rate(1, 218000, 50000, REGION_BACKOFF, 1000)});
        directed_rows.push_back('{mk_sample(1, 100000, 1, 256000, 1, 5, 300), 1'b1,
                                  mk_rate(1, 5, 99000, REGION_BACKOFF, 1000)});
        // saturation at full throughput, then a cap above a zero rate
        directed_rows.push_back('{mk_sample(1, 500, 1, RATE_MAX, 0, 0, 400), 1'b1,
                                  mk_rate(1, RATE_MAX, 0, REGION_PROBE, 500)});
        directed_rows.push_back('{mk_sample(1, 500, 1, 0, 1, RATE_MAX, 500), 1'b1,
                                  mk_rate(1, 0, 0, REGION_PROBE, 500)});
        directed_rows.push_back('{mk_sample(0, 0, 0, 0, 1, 0, 600), 1'b1,
                                  mk_rate(0, 0, 0, REGION_PROBE, 500)});
        directed_rows.push_back('{mk_sample(1, 32'hFFFF_FFFF, 1, 1024, 1, 0, 700), 1'b1,
                                  mk_rate(1, 0, 32'hFFFF_FE0B, REGION_BACKOFF, 500)});
        // threshold edges
        directed_rows.push_back('{mk_sample(1, 10500, 1, 256, 0, 0, 800), 1'b1,
                                  mk_rate(1, 384, 10000, REGION_PROBE, 500)});
        directed_rows.push_back('{mk_sample(1, 10501, 1, 256, 0, 0, 900), 1'b1,
                                  mk_rate(1, 256, 10001, REGION_HOLD, 500)});
        directed_rows.push_back('{mk_sample(1, 50499, 1, 256, 0, 0, 1000), 1'b1,
                                  mk_rate(1, 256, 49999, REGION_HOLD, 500)});
        // window edge, expiry, base rising, timestamp wrap
        directed_rows.push_back('{mk_sample(1, 800, 1, 40'h12_3456_789A, 0, 0, 10000000),
                                  1'b0, '0});
        directed_rows.push_back('{mk_sample(1, 800, 1, 40'h12_3456_789A, 1, 40'h10_0000_0000,
                                            10000001), 1'b0, '0});
        directed_rows.push_back('{mk_sample(1, 900, 1, 40'hAB_CDEF_0123, 0, 0, 20000002),
                                  1'b0, '0});
        directed_rows.push_back('{mk_sample(1, 2000, 1, 1000, 0, 0, 48'hFFFF_FFFF_FFFF),
                                  1'b0, '0});
        directed_rows.push_back('{mk_sample(1, 2000, 1, 1000, 1, 40'hFF, 5), 1'b0, '0});
        directed_rows.push_back('{mk_sample(1, 75000, 1, 40'h55_AAAA_5555, 1, 40'hAA_5555_AAAA,
                                            48'hAAAA_5555_AAAA), 1'b0, '0});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

        run_phase(0, 1, 256, 1, 1, 34, 46);
        run_phase(10000000, 10000000, 2560, 256, 32'd3600000000, 34, 46);
        run_phase(20000, 5000, 4095, 0, 32'hFFFF_FFFF, 46, 34);
        run_phase(32'h00FF_FFFF, 32'h00FF_FFFF, 0, 511, 0, 46, 34);
        run_phase(1000, 4000, 300, 200, 50000, 0, 0);
        run_phase(LOW_THRESH_RST, HIGH_THRESH_RST, HEADROOM_RST, BACKOFF_RST, WINDOW_RST, 0, 0);

        drain();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### delay_based_rate_target.f
rtl/dbrt_pkg.sv
rtl/dbrt_if.sv
rtl/dbrt_base_track.sv
rtl/delay_based_rate_target.sv
rtl/dbrt_checker.sv
tb/delay_based_rate_target_tb.sv
